[hw/rtl/pzt_pkg.sv]
// Package for the piezo tension ramp: action codes, sequencer states and
// fixed constants. No dependencies.
package pzt_pkg;

   localparam logic signed [17:0] DIAMOND_MAX = 18'sd25600;
   localparam logic [28:0]        LIMIT_MAX   = 29'd429496730;
   localparam logic [28:0]        LIMIT_RESET = 29'd4295;
   localparam logic [15:0]        CODE_MID    = 16'd32767;
   localparam int                 CODE_GAIN   = 327;

   typedef enum logic [2:0] {
      ACT_TGT_B   = 3'd0,
      ACT_TGT_A   = 3'd1,
      ACT_SPD_B   = 3'd2,
      ACT_SPD_A   = 3'd3,
      ACT_SPD_ALL = 3'd4,
      ACT_TICK    = 3'd5
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF0,
      ST_DIFF1,
      ST_ABS,
      ST_NORM,
      ST_SQ1,
      ST_SQ2,
      ST_SQ3,
      ST_SQRT,
      ST_MUL,
      ST_DIV,
      ST_STEP,
      ST_TMUL,
      ST_TMOVE,
      ST_TCODE,
      ST_TEND
   } state_type;

endpackage

[hw/rtl/piezo_tension_ramp.sv]
// Piezo tension ramp top level: command decode, step vector sequencer with
// a shared multiplier and compare/subtract unit, tick sweep. Uses pzt_pkg.
//
//   channel | ports                           | direction | handshake
//   --------+---------------------------------+-----------+-----------------
//   req     | action coord_y coord_z          | in        | valid / stall
//           | speed_limit elapsed             |           |
//   rsp     | channel dac_code last           | out       | valid / stall
//   csr     | write_enable write_data         | in        | write, no wait
//
// Target and single speed commands shift the difference magnitudes down in a
// loop, then run a 32-step square root and two 59-step divisions, both on the
// one compare/subtract unit; a pair already at its goal just gets zero steps.
// Speed-both runs the step vector for pair B, if present, then pair A.
// A tick runs multiply, move and code states per channel, then an end state;
// rsp stalls hold it. No reset clearing pass. req_stall is high while busy.
module piezo_tension_ramp #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic signed [15:0] req_coord_y,
   input  logic signed [15:0] req_coord_z,
   input  logic signed [30:0] req_speed_limit,
   input  logic [15:0]        req_elapsed,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_channel,
   output logic [15:0]        rsp_dac_code,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);

   localparam int IW    = $clog2(NUM_CHANNELS);
   localparam bit HAS_B = (NUM_CHANNELS >= 4);

   pzt_pkg::state_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic pair_ff, pair_in, both_ff, both_in, sel_ff, sel_in;
   logic enable_ff, enable_in;
   logic [28:0] limit_ff [2];
   logic [28:0] limit_in [2];
   logic signed [39:0] now_ff  [NUM_CHANNELS];
   logic signed [39:0] now_in  [NUM_CHANNELS];
   logic signed [39:0] goal_ff [NUM_CHANNELS];
   logic signed [39:0] goal_in [NUM_CHANNELS];
   logic signed [30:0] step_ff [NUM_CHANNELS];
   logic signed [30:0] step_in [NUM_CHANNELS];
   logic [15:0] last_ff [NUM_CHANNELS];
   logic [15:0] last_in [NUM_CHANNELS];
   logic [15:0] el_ff, el_in;
   logic signed [40:0] d1_ff, d1_in, d2_ff, d2_in;
   logic [40:0] a1_ff, a1_in, a2_ff, a2_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0] x_ff, x_in, r_ff, r_in, bit_ff, bit_in;
   logic [31:0] n_ff, n_in, rem_ff, rem_in;
   logic [58:0] dvd_ff, dvd_in, q_ff, q_in;
   logic [5:0] cnt_ff, cnt_in;
   logic pend_valid_ff, pend_valid_in;
   logic [IW-1:0] pend_chan_ff, pend_chan_in;
   logic [15:0] pend_code_ff, pend_code_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [1:0] rsp_chan_ff, rsp_chan_in;
   logic [15:0] rsp_code_ff, rsp_code_in;

   // shared datapath
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic [63:0] cs_a, cs_b, cs_diff;
   logic cs_ge;

   // command decode
   logic signed [17:0] fy, fz, ay, az, zc, azc, yf, v1, v2;
   logic signed [39:0] g1, g2;
   logic [28:0] lim_w;
   logic [IW-1:0] base_w;
   logic signed [49:0] code_acc;
   logic [15:0] code_w;
   logic signed [47:0] reach_w;
   logic [40:0] dmag_w;
   logic [47:0] rmag_w;
   logic [32:0] rs_w;
   logic [63:0] r_next;
   logic out_free;

   assign mul_p   = mul_a * mul_b;
   assign cs_ge   = (cs_a >= cs_b);
   assign cs_diff = cs_a - cs_b;

   assign req_stall    = (state_ff != pzt_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_channel  = rsp_chan_ff;
   assign rsp_dac_code = rsp_code_ff;
   assign rsp_last     = rsp_last_ff;
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // diamond fold, pair A negated
   always_comb begin
      fy = 18'(req_coord_y);
      fz = 18'(req_coord_z);
      if (req_action == pzt_pkg::ACT_TGT_A) begin
         fy = -fy;
         fz = -fz;
      end
      ay = (fy < 0) ? -fy : fy;
      az = (fz < 0) ? -fz : fz;
      zc = fz;
      yf = fy;
      azc = az;
      if (ay + az > pzt_pkg::DIAMOND_MAX) begin
         if (fz > pzt_pkg::DIAMOND_MAX) zc = pzt_pkg::DIAMOND_MAX;
         else if (fz < -pzt_pkg::DIAMOND_MAX) zc = -pzt_pkg::DIAMOND_MAX;
         azc = (zc < 0) ? -zc : zc;
         if (fy > 0) yf = pzt_pkg::DIAMOND_MAX - azc;
         else if (fy < 0) yf = azc - pzt_pkg::DIAMOND_MAX;
      end
      v1 = yf - zc;
      v2 = yf + zc;
      g1 = $signed({v1[15:0], 24'd0});
      g2 = $signed({v2[15:0], 24'd0});
      if (req_speed_limit < 0) lim_w = '0;
      else if (req_speed_limit > $signed({2'b00, pzt_pkg::LIMIT_MAX}))
         lim_w = pzt_pkg::LIMIT_MAX;
      else lim_w = req_speed_limit[28:0];
   end

   always_comb begin
      base_w   = pair_ff ? IW'(2) : '0;
      code_acc = 50'(now_ff[idx_ff]) * 50'(pzt_pkg::CODE_GAIN)
               + $signed({2'b00, pzt_pkg::CODE_MID, 32'd0});
      code_w   = code_acc[47:32];
      reach_w  = prod_ff[47:0];
      dmag_w   = d1_ff[40] ? 41'(-d1_ff) : 41'(d1_ff);
      rmag_w   = reach_w[47] ? 48'(-reach_w) : 48'(reach_w);
      rs_w     = {rem_ff, dvd_ff[58]};
   end

   always_comb begin
      state_in = state_ff;  idx_in = idx_ff;  pair_in = pair_ff;
      both_in = both_ff;    sel_in = sel_ff;  enable_in = enable_ff;
      limit_in = limit_ff;  now_in = now_ff;  goal_in = goal_ff;
      step_in = step_ff;    last_in = last_ff; el_in = el_ff;
      d1_in = d1_ff; d2_in = d2_ff; a1_in = a1_ff; a2_in = a2_ff;
      prod_in = prod_ff; x_in = x_ff; r_in = r_ff; bit_in = bit_ff;
      n_in = n_ff; rem_in = rem_ff; dvd_in = dvd_ff; q_in = q_ff; cnt_in = cnt_ff;
      pend_valid_in = pend_valid_ff; pend_chan_in = pend_chan_ff;
      pend_code_in = pend_code_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_chan_in = rsp_chan_ff; rsp_code_in = rsp_code_ff; rsp_last_in = rsp_last_ff;
      mul_a = '0; mul_b = '0; cs_a = '0; cs_b = '0;
      r_next = '0;

      if (csr_write_enable) enable_in = csr_write_data;

      unique case (state_ff)
         pzt_pkg::ST_IDLE: begin
            if (req_valid) begin
               el_in = req_elapsed;
               unique case (pzt_pkg::action_type'(req_action))
                  pzt_pkg::ACT_TGT_B: begin
                     if (HAS_B) begin
                        goal_in[IW'(2)] = g1;
                        goal_in[IW'(3)] = g2;
                        pair_in = 1'b1; idx_in = IW'(2);
                        state_in = pzt_pkg::ST_DIFF0;
                     end
                  end
                  pzt_pkg::ACT_TGT_A: begin
                     goal_in[0] = g1;
                     goal_in[1] = g2;
                     pair_in = 1'b0; idx_in = '0;
                     state_in = pzt_pkg::ST_DIFF0;
                  end
                  pzt_pkg::ACT_SPD_B: begin
                     limit_in[1] = lim_w;
                     if (HAS_B) begin
                        pair_in = 1'b1; idx_in = IW'(2);
                        state_in = pzt_pkg::ST_DIFF0;
                     end
                  end
                  pzt_pkg::ACT_SPD_A: begin
                     limit_in[0] = lim_w;
                     pair_in = 1'b0; idx_in = '0;
                     state_in = pzt_pkg::ST_DIFF0;
                  end
                  pzt_pkg::ACT_SPD_ALL: begin
                     limit_in[0] = lim_w;
                     limit_in[1] = lim_w;
                     if (HAS_B) begin
                        pair_in = 1'b1; idx_in = IW'(2); both_in = 1'b1;
                     end else begin
                        pair_in = 1'b0; idx_in = '0;
                     end
                     state_in = pzt_pkg::ST_DIFF0;
                  end
                  pzt_pkg::ACT_TICK: begin
                     if (enable_ff) begin
                        idx_in = '0;
                        state_in = pzt_pkg::ST_TMUL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         pzt_pkg::ST_DIFF0: begin
            d1_in = 41'(goal_ff[idx_ff]) - 41'(now_ff[idx_ff]);
            idx_in = IW'(idx_ff + 1'b1);
            state_in = pzt_pkg::ST_DIFF1;
         end
         pzt_pkg::ST_DIFF1: begin
            d2_in = 41'(goal_ff[idx_ff]) - 41'(now_ff[idx_ff]);
            state_in = pzt_pkg::ST_ABS;
         end
         pzt_pkg::ST_ABS: begin
            a1_in = d1_ff[40] ? 41'(-d1_ff) : 41'(d1_ff);
            a2_in = d2_ff[40] ? 41'(-d2_ff) : 41'(d2_ff);
            state_in = pzt_pkg::ST_NORM;
         end
         pzt_pkg::ST_NORM: begin
            priority if (a1_ff == '0 && a2_ff == '0) begin
               step_in[base_w] = '0;
               step_in[IW'(base_w + 1'b1)] = '0;
               if (both_ff) begin
                  both_in = 1'b0; pair_in = 1'b0; idx_in = '0;
                  state_in = pzt_pkg::ST_DIFF0;
               end else state_in = pzt_pkg::ST_IDLE;
            end else if (a1_ff[40:30] != '0 || a2_ff[40:30] != '0) begin
               a1_in = a1_ff >> 1;
               a2_in = a2_ff >> 1;
            end else begin
               state_in = pzt_pkg::ST_SQ1;
            end
         end
         pzt_pkg::ST_SQ1: begin
            mul_a = $signed({2'b00, a1_ff[29:0]});
            mul_b = $signed({2'b00, a1_ff[29:0]});
            prod_in = mul_p;
            state_in = pzt_pkg::ST_SQ2;
         end
         pzt_pkg::ST_SQ2: begin
            mul_a = $signed({2'b00, a2_ff[29:0]});
            mul_b = $signed({2'b00, a2_ff[29:0]});
            x_in = 64'(prod_ff);
            prod_in = mul_p;
            state_in = pzt_pkg::ST_SQ3;
         end
         pzt_pkg::ST_SQ3: begin
            x_in = x_ff + 64'(prod_ff);
            r_in = '0;
            bit_in = 64'd1 << 62;
            state_in = pzt_pkg::ST_SQRT;
         end
         pzt_pkg::ST_SQRT: begin
            cs_a = x_ff;
            cs_b = r_ff + bit_ff;
            if (cs_ge) begin
               x_in = cs_diff;
               r_next = (r_ff >> 1) + bit_ff;
            end else begin
               r_next = r_ff >> 1;
            end
            r_in = r_next;
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               n_in = (r_next[31:0] == '0) ? 32'd1 : r_next[31:0];
               sel_in = 1'b0;
               state_in = pzt_pkg::ST_MUL;
            end
         end
         pzt_pkg::ST_MUL: begin
            mul_a = $signed({3'b000, limit_ff[pair_ff]});
            mul_b = sel_ff ? $signed({2'b00, a2_ff[29:0]})
                           : $signed({2'b00, a1_ff[29:0]});
            dvd_in = mul_p[58:0];
            rem_in = '0;
            q_in = '0;
            cnt_in = 6'd58;
            state_in = pzt_pkg::ST_DIV;
         end
         pzt_pkg::ST_DIV: begin
            cs_a = 64'(rs_w);
            cs_b = 64'(n_ff);
            rem_in = cs_ge ? cs_diff[31:0] : rs_w[31:0];
            q_in = {q_ff[57:0], cs_ge};
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = pzt_pkg::ST_STEP;
         end
         pzt_pkg::ST_STEP: begin
            if ((sel_ff ? d2_ff[40] : d1_ff[40]))
               step_in[IW'(base_w + IW'(sel_ff))] = -$signed({1'b0, q_ff[29:0]});
            else
               step_in[IW'(base_w + IW'(sel_ff))] = $signed({1'b0, q_ff[29:0]});
            if (!sel_ff) begin
               sel_in = 1'b1;
               state_in = pzt_pkg::ST_MUL;
            end else if (both_ff) begin
               both_in = 1'b0; pair_in = 1'b0; idx_in = '0;
               state_in = pzt_pkg::ST_DIFF0;
            end else state_in = pzt_pkg::ST_IDLE;
         end
         pzt_pkg::ST_TMUL: begin
            mul_a = 32'(step_ff[idx_ff]);
            mul_b = $signed({16'd0, el_ff});
            prod_in = mul_p;
            d1_in = 41'(now_ff[idx_ff]) - 41'(goal_ff[idx_ff]);
            state_in = pzt_pkg::ST_TMOVE;
         end
         pzt_pkg::ST_TMOVE: begin
            if (48'(dmag_w) <= rmag_w) begin
               now_in[idx_ff] = goal_ff[idx_ff];
               step_in[idx_ff] = '0;
            end else begin
               now_in[idx_ff] = 40'(48'(now_ff[idx_ff]) + reach_w);
            end
            state_in = pzt_pkg::ST_TCODE;
         end
         pzt_pkg::ST_TCODE: begin
            // a word is held back one slot so the final one can carry last
            if (code_w == last_ff[idx_ff] || !pend_valid_ff || out_free) begin
               if (code_w != last_ff[idx_ff]) begin
                  last_in[idx_ff] = code_w;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_chan_in = 2'(pend_chan_ff);
                     rsp_code_in = pend_code_ff;
                     rsp_last_in = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_chan_in = idx_ff;
                  pend_code_in = code_w;
               end
               if (idx_ff == IW'(NUM_CHANNELS - 1)) state_in = pzt_pkg::ST_TEND;
               else begin
                  idx_in = IW'(idx_ff + 1'b1);
                  state_in = pzt_pkg::ST_TMUL;
               end
            end
         end
         pzt_pkg::ST_TEND: begin
            if (!pend_valid_ff) state_in = pzt_pkg::ST_IDLE;
            else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_chan_in = 2'(pend_chan_ff);
               rsp_code_in = pend_code_ff;
               rsp_last_in = 1'b1;
               pend_valid_in = 1'b0;
               state_in = pzt_pkg::ST_IDLE;
            end
         end
         default: state_in = pzt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pzt_pkg::ST_IDLE;
         both_ff <= 1'b0;
         enable_ff <= 1'b1;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff[0] <= pzt_pkg::LIMIT_RESET;
         limit_ff[1] <= pzt_pkg::LIMIT_RESET;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            now_ff[i] <= '0;
            goal_ff[i] <= '0;
            step_ff[i] <= '0;
            last_ff[i] <= pzt_pkg::CODE_MID;
         end
      end else begin
         state_ff <= state_in;
         both_ff <= both_in;
         enable_ff <= enable_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff <= limit_in;
         now_ff <= now_in;
         goal_ff <= goal_in;
         step_ff <= step_in;
         last_ff <= last_in;
      end
      idx_ff <= idx_in;  pair_ff <= pair_in;  sel_ff <= sel_in;  el_ff <= el_in;
      d1_ff <= d1_in; d2_ff <= d2_in; a1_ff <= a1_in; a2_ff <= a2_in;
      prod_ff <= prod_in; x_ff <= x_in; r_ff <= r_in; bit_ff <= bit_in;
      n_ff <= n_in; rem_ff <= rem_in; dvd_ff <= dvd_in; q_ff <= q_in; cnt_ff <= cnt_in;
      pend_chan_ff <= pend_chan_in; pend_code_ff <= pend_code_in;
      rsp_chan_ff <= rsp_chan_in; rsp_code_ff <= rsp_code_in; rsp_last_ff <= rsp_last_in;
   end

`ifndef ASSERT_OFF
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == pzt_pkg::ST_DIV |-> rem_ff < n_ff)
      else $error("division remainder not below divisor");

   a_sqrt_bit_onehot: assert property (@(posedge clock) disable iff (reset)
      state_ff == pzt_pkg::ST_SQRT |-> $onehot(bit_ff))
      else $error("square root bit not one-hot");

   a_step_within_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == pzt_pkg::ST_STEP |-> q_ff <= 59'(pzt_pkg::LIMIT_MAX))
      else $error("step magnitude above speed limit");

   a_pend_only_in_tick: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == pzt_pkg::ST_TMUL || state_ff == pzt_pkg::ST_TMOVE
                         || state_ff == pzt_pkg::ST_TCODE || state_ff == pzt_pkg::ST_TEND))
      else $error("held word outside a tick");

   a_idle_after_tick_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pzt_pkg::ST_TEND && !pend_valid_ff) |=> state_ff == pzt_pkg::ST_IDLE)
      else $error("tick did not finish");
`endif

endmodule
